[rtl/core/tcce_pkg.sv]
// Shared types, constants and address helpers for the text console character engine.
package tcce_pkg;

    // Screen geometry and tab stops.
    localparam int SCREEN_COLS = 80;
    localparam int SCREEN_ROWS = 25;
    // Tab stops are a power of two apart, so the column remainder is a mask.
    localparam int TAB_WIDTH   = 8;
    localparam int CELL_COUNT  = SCREEN_COLS * SCREEN_ROWS;
    localparam int ADDR_W      = $clog2(CELL_COUNT);

    // Field widths.
    localparam int CMD_W  = 3;
    localparam int CHAR_W = 8;
    localparam int COL_W  = 7;
    localparam int ROW_W  = 5;
    localparam int POS_W  = 11;
    localparam int ATTR_W = 8;
    localparam int CELL_W = CHAR_W + ATTR_W;

    // Stream payload widths, padded to whole bytes.
    localparam int S_FIELDS_W = CMD_W + CHAR_W + COL_W + ROW_W;
    localparam int S_TDATA_W  = ((S_FIELDS_W + 7) / 8) * 8;
    localparam int M_FIELDS_W = POS_W + COL_W + ROW_W + CELL_W;
    localparam int M_TDATA_W  = ((M_FIELDS_W + 7) / 8) * 8;

    // Character codes.
    localparam logic [CHAR_W-1:0] CH_BS    = 8'h08;
    localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
    localparam logic [CHAR_W-1:0] CH_LF    = 8'h0A;
    localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
    localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;

    // Attribute after reset and the blank cell that reset leaves in the store.
    localparam logic [ATTR_W-1:0] RESET_ATTR  = 8'h0F;
    localparam logic [CELL_W-1:0] RESET_BLANK = {RESET_ATTR, CH_SPACE};

    // Commands.
    typedef enum logic [CMD_W-1:0] {
        CMD_PUT     = 3'd0,
        CMD_READ    = 3'd1,
        CMD_CLEAR   = 3'd2,
        CMD_MOVE    = 3'd3,
        CMD_SAVE    = 3'd4,
        CMD_RESTORE = 3'd5
    } cmd_t;

    // Sequencer states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_SCROLL,
        ST_DRAIN,
        ST_FILL,
        ST_RESP
    } state_t;

    // Linear cell address of a row and column.
    function automatic logic [ADDR_W-1:0] cell_addr(input logic [ROW_W-1:0] r,
                                                    input logic [COL_W-1:0] c);
        cell_addr = ADDR_W'(r) * ADDR_W'(SCREEN_COLS) + ADDR_W'(c);
    endfunction

    // Clamp a column to the last column of the screen.
    function automatic logic [COL_W-1:0] sat_col(input logic [COL_W-1:0] c);
        sat_col = (COL_W'(c) >= COL_W'(SCREEN_COLS)) ? COL_W'(SCREEN_COLS - 1) : c;
    endfunction

    // Clamp a row to the last row of the screen.
    function automatic logic [ROW_W-1:0] sat_row(input logic [ROW_W-1:0] r);
        sat_row = (r >= ROW_W'(SCREEN_ROWS)) ? ROW_W'(SCREEN_ROWS - 1) : r;
    endfunction

endpackage

[rtl/core/tcce_ram.sv]
// Generic simple dual-port RAM with one write port and one registered read port.
module tcce_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2000
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read; a same-address read returns the old word.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

[rtl/core/text_console_character_engine_unit.sv]
// Top level of the text console character engine: command sequencer around the cell store.
//
//  Channel  Direction  Handshake                Payload
//  s_       in         s_tvalid / s_tready      s_tdata: cmd, ch, col, row
//  m_       out        m_tvalid / m_tready      m_tdata: cursor_position, cursor_col,
//                                               cursor_row, cell_data
//  cfg_     in         cfg_valid / cfg_ready    cfg_data: text_attribute
//
// Move, save, restore and put character without scroll go from idle to the response state.
// Read cell passes through the read state to take the registered read of the cell store.
// Clear writes one cell per cycle. A scroll first copies 1920 cells up one row through
// the store's read and write ports, then blanks the 80 cells of the bottom row.
// After reset the store is blanked while s_tready stays low.
// s_tready is high only while the sequencer idles; a held result keeps the next command
// in its last cycle, with s_tready low, until m_tready frees the output register.
module text_console_character_engine_unit (
    input  logic                               aclk,
    input  logic                               aresetn,
    // Input beats.
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // [2:0] cmd, [10:3] ch, [17:11] col, [22:18] row, [23] zero
    input  logic [tcce_pkg::S_TDATA_W-1:0]     s_tdata,
    // Result beats.
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // [10:0] cursor_position, [17:11] cursor_col, [22:18] cursor_row,
    // [38:23] cell_data, [39] zero
    output logic [tcce_pkg::M_TDATA_W-1:0]     m_tdata,
    // Attribute register writes.
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [tcce_pkg::ATTR_W-1:0]        cfg_data
);

    // Input field unpacking.
    logic [tcce_pkg::CMD_W-1:0]  s_cmd;
    logic [tcce_pkg::CHAR_W-1:0] s_ch;
    logic [tcce_pkg::COL_W-1:0]  s_col;
    logic [tcce_pkg::ROW_W-1:0]  s_row;

    assign s_cmd = s_tdata[tcce_pkg::CMD_W-1:0];
    assign s_ch  = s_tdata[tcce_pkg::CMD_W +: tcce_pkg::CHAR_W];
    assign s_col = s_tdata[tcce_pkg::CMD_W + tcce_pkg::CHAR_W +: tcce_pkg::COL_W];
    assign s_row = s_tdata[tcce_pkg::CMD_W + tcce_pkg::CHAR_W + tcce_pkg::COL_W +:
                           tcce_pkg::ROW_W];

    // Registers.
    tcce_pkg::state_t                 state_reg, state_next;
    logic [tcce_pkg::ADDR_W-1:0]      sweep_reg, sweep_next;
    logic                             fill_init_reg, fill_init_next;
    logic                             wr_pend_reg, wr_pend_next;
    logic [tcce_pkg::ADDR_W-1:0]      wr_addr_reg, wr_addr_next;
    logic [tcce_pkg::COL_W-1:0]       cur_col_reg, cur_col_next;
    logic [tcce_pkg::ROW_W-1:0]       cur_row_reg, cur_row_next;
    logic [tcce_pkg::COL_W-1:0]       saved_col_reg, saved_col_next;
    logic [tcce_pkg::ROW_W-1:0]       saved_row_reg, saved_row_next;
    logic [tcce_pkg::ATTR_W-1:0]      attr_reg, attr_next;
    logic [tcce_pkg::CELL_W-1:0]      data_reg, data_next;
    logic                             m_valid_reg, m_valid_next;
    logic [tcce_pkg::M_TDATA_W-1:0]   m_data_reg, m_data_next;

    // Cell store ports.
    logic                             ram_wen;
    logic [tcce_pkg::ADDR_W-1:0]      ram_waddr;
    logic [tcce_pkg::CELL_W-1:0]      ram_wdata;
    logic [tcce_pkg::ADDR_W-1:0]      ram_raddr;
    logic [tcce_pkg::CELL_W-1:0]      ram_rdata;

    // Put character scratch: one extra bit to see the wrap and the scroll.
    logic [tcce_pkg::COL_W:0]         pc_col;
    logic [tcce_pkg::ROW_W:0]         pc_row;
    logic [tcce_pkg::CELL_W-1:0]      blank_cell;
    logic                             s_accept;

    assign blank_cell = {attr_reg, tcce_pkg::CH_SPACE};
    assign s_tready   = (state_reg == tcce_pkg::ST_IDLE);
    assign s_accept   = s_tvalid && s_tready;
    assign cfg_ready  = 1'b1;
    assign m_tvalid   = m_valid_reg;
    assign m_tdata    = m_data_reg;

    tcce_ram #(
        .WIDTH (tcce_pkg::CELL_W),
        .DEPTH (tcce_pkg::CELL_COUNT)
    ) u_cells (
        .aclk    (aclk),
        .wr_en   (ram_wen),
        .wr_addr (ram_waddr),
        .wr_data (ram_wdata),
        .rd_addr (ram_raddr),
        .rd_data (ram_rdata)
    );

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= tcce_pkg::ST_FILL;
            sweep_reg     <= '0;
            fill_init_reg <= 1'b1;
            wr_pend_reg   <= 1'b0;
            cur_col_reg   <= '0;
            cur_row_reg   <= '0;
            saved_col_reg <= '0;
            saved_row_reg <= '0;
            attr_reg      <= tcce_pkg::RESET_ATTR;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            sweep_reg     <= sweep_next;
            fill_init_reg <= fill_init_next;
            wr_pend_reg   <= wr_pend_next;
            cur_col_reg   <= cur_col_next;
            cur_row_reg   <= cur_row_next;
            saved_col_reg <= saved_col_next;
            saved_row_reg <= saved_row_next;
            attr_reg      <= attr_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        wr_addr_reg <= wr_addr_next;
        data_reg    <= data_next;
        m_data_reg  <= m_data_next;
    end

    // Sequencer: next state, store accesses and cursor updates.
    always_comb begin
        state_next     = state_reg;
        sweep_next     = sweep_reg;
        fill_init_next = fill_init_reg;
        wr_pend_next   = wr_pend_reg;
        wr_addr_next   = wr_addr_reg;
        cur_col_next   = cur_col_reg;
        cur_row_next   = cur_row_reg;
        saved_col_next = saved_col_reg;
        saved_row_next = saved_row_reg;
        attr_next      = attr_reg;
        data_next      = data_reg;
        m_data_next    = m_data_reg;
        m_valid_next   = m_valid_reg && !m_tready;
        ram_wen        = 1'b0;
        ram_waddr      = sweep_reg;
        ram_wdata      = blank_cell;
        ram_raddr      = sweep_reg;
        pc_col         = {1'b0, cur_col_reg};
        pc_row         = {1'b0, cur_row_reg};

        // Attribute register writes are taken in any state.
        if (cfg_valid && cfg_ready) begin
            attr_next = cfg_data;
        end

        case (state_reg)
            tcce_pkg::ST_IDLE: begin
                if (s_accept) begin
                    data_next  = '0;
                    state_next = tcce_pkg::ST_RESP;
                    case (s_cmd)
                        tcce_pkg::CMD_PUT: begin
                            // Control bytes, printable bytes, then wrap and scroll.
                            case (s_ch)
                                tcce_pkg::CH_BS: begin
                                    if (cur_col_reg != '0) begin
                                        pc_col    = pc_col - 1'b1;
                                        ram_wen   = 1'b1;
                                        ram_waddr = tcce_pkg::cell_addr(cur_row_reg,
                                                        cur_col_reg - 1'b1);
                                        ram_wdata = blank_cell;
                                    end
                                end
                                tcce_pkg::CH_TAB: begin
                                    pc_col = (pc_col &
                                              ~((tcce_pkg::COL_W + 1)'(tcce_pkg::TAB_WIDTH - 1)))
                                             + (tcce_pkg::COL_W + 1)'(tcce_pkg::TAB_WIDTH);
                                end
                                tcce_pkg::CH_CR: begin
                                    pc_col = '0;
                                end
                                tcce_pkg::CH_LF: begin
                                    pc_col = '0;
                                    pc_row = pc_row + 1'b1;
                                end
                                default: begin
                                    if (s_ch >= tcce_pkg::CH_SPACE) begin
                                        ram_wen   = 1'b1;
                                        ram_waddr = tcce_pkg::cell_addr(cur_row_reg,
                                                                        cur_col_reg);
                                        ram_wdata = {attr_reg, s_ch};
                                        pc_col    = pc_col + 1'b1;
                                    end
                                end
                            endcase
                            if (pc_col >= (tcce_pkg::COL_W + 1)'(tcce_pkg::SCREEN_COLS)) begin
                                pc_col = '0;
                                pc_row = pc_row + 1'b1;
                            end
                            cur_col_next = pc_col[tcce_pkg::COL_W-1:0];
                            if (pc_row >= (tcce_pkg::ROW_W + 1)'(tcce_pkg::SCREEN_ROWS)) begin
                                cur_row_next = tcce_pkg::ROW_W'(tcce_pkg::SCREEN_ROWS - 1);
                                sweep_next   = tcce_pkg::ADDR_W'(tcce_pkg::SCREEN_COLS);
                                wr_pend_next = 1'b0;
                                state_next   = tcce_pkg::ST_SCROLL;
                            end else begin
                                cur_row_next = pc_row[tcce_pkg::ROW_W-1:0];
                            end
                        end
                        tcce_pkg::CMD_READ: begin
                            ram_raddr  = tcce_pkg::cell_addr(tcce_pkg::sat_row(s_row),
                                                             tcce_pkg::sat_col(s_col));
                            state_next = tcce_pkg::ST_READ;
                        end
                        tcce_pkg::CMD_CLEAR: begin
                            cur_col_next   = '0;
                            cur_row_next   = '0;
                            sweep_next     = '0;
                            fill_init_next = 1'b0;
                            state_next     = tcce_pkg::ST_FILL;
                        end
                        tcce_pkg::CMD_MOVE: begin
                            cur_col_next = tcce_pkg::sat_col(s_col);
                            cur_row_next = tcce_pkg::sat_row(s_row);
                        end
                        tcce_pkg::CMD_SAVE: begin
                            saved_col_next = cur_col_reg;
                            saved_row_next = cur_row_reg;
                        end
                        tcce_pkg::CMD_RESTORE: begin
                            cur_col_next = saved_col_reg;
                            cur_row_next = saved_row_reg;
                        end
                        default: begin
                        end
                    endcase
                end
            end

            // Read data of the cell store arrives in the cycle after the address.
            tcce_pkg::ST_READ: begin
                data_next  = ram_rdata;
                state_next = tcce_pkg::ST_RESP;
            end

            // Copy each cell one row up: read ahead, write the previous read behind.
            tcce_pkg::ST_SCROLL: begin
                ram_raddr    = sweep_reg;
                ram_wen      = wr_pend_reg;
                ram_waddr    = wr_addr_reg;
                ram_wdata    = ram_rdata;
                wr_pend_next = 1'b1;
                wr_addr_next = sweep_reg - tcce_pkg::ADDR_W'(tcce_pkg::SCREEN_COLS);
                if (sweep_reg == tcce_pkg::ADDR_W'(tcce_pkg::CELL_COUNT - 1)) begin
                    state_next = tcce_pkg::ST_DRAIN;
                end else begin
                    sweep_next = sweep_reg + 1'b1;
                end
            end

            // Last copied cell, then blank the bottom row.
            tcce_pkg::ST_DRAIN: begin
                ram_wen        = 1'b1;
                ram_waddr      = wr_addr_reg;
                ram_wdata      = ram_rdata;
                wr_pend_next   = 1'b0;
                sweep_next     = tcce_pkg::ADDR_W'(tcce_pkg::CELL_COUNT - tcce_pkg::SCREEN_COLS);
                fill_init_next = 1'b0;
                state_next     = tcce_pkg::ST_FILL;
            end

            // Blank cells from the sweep address to the end of the store.
            tcce_pkg::ST_FILL: begin
                ram_wen   = 1'b1;
                ram_waddr = sweep_reg;
                ram_wdata = fill_init_reg ? tcce_pkg::RESET_BLANK : blank_cell;
                if (sweep_reg == tcce_pkg::ADDR_W'(tcce_pkg::CELL_COUNT - 1)) begin
                    fill_init_next = 1'b0;
                    state_next     = fill_init_reg ? tcce_pkg::ST_IDLE : tcce_pkg::ST_RESP;
                end else begin
                    sweep_next = sweep_reg + 1'b1;
                end
            end

            // Hand the result to the output register once it is free.
            tcce_pkg::ST_RESP: begin
                if (!m_valid_reg || m_tready) begin
                    m_valid_next = 1'b1;
                    m_data_next  = tcce_pkg::M_TDATA_W'({data_reg, cur_row_reg, cur_col_reg,
                                       tcce_pkg::cell_addr(cur_row_reg, cur_col_reg)});
                    state_next   = tcce_pkg::ST_IDLE;
                end
            end

            default: begin
                state_next = tcce_pkg::ST_IDLE;
            end
        endcase
    end

`ifndef SYNTHESIS
    // The cursor always lies on the screen.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (cur_col_reg < tcce_pkg::COL_W'(tcce_pkg::SCREEN_COLS)) &&
        (cur_row_reg < tcce_pkg::ROW_W'(tcce_pkg::SCREEN_ROWS)))
        else $error("cursor left the screen");

    // Every store write lands inside the store.
    assert property (@(posedge aclk) disable iff (!aresetn)
        ram_wen |-> (ram_waddr < tcce_pkg::ADDR_W'(tcce_pkg::CELL_COUNT)))
        else $error("cell store write out of range");

    // During a scroll the pending write trails the read by one row plus one cell.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == tcce_pkg::ST_SCROLL && wr_pend_reg) |->
        (wr_addr_reg + tcce_pkg::ADDR_W'(tcce_pkg::SCREEN_COLS) + 1'b1 == sweep_reg))
        else $error("scroll copy lost its row offset");

    // One beat at a time: an accepted beat closes the input until its result is loaded into the output register.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept |=> !s_tready)
        else $error("input accepted while a command was in flight");

    // A result is only loaded into a free or draining output register.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_tready) |=> $stable(m_data_reg))
        else $error("pending result overwritten");
`endif

endmodule
